@@ design/bfa_pkg.sv @@
// Package for the best-fit allocator: sizes, widths, the scan token and
// the broadcast control word shared by the cell row and the top level.
// No dependencies.
package bfa_pkg;

  localparam int BLOCKS     = 16;
  localparam int SIZE_WIDTH = 16;
  localparam int IDX_W      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int AMT_W      = 16;   // amount field width
  localparam int NUM_W      = 4;    // block_number field width
  localparam int LEFT_W     = 16;   // leftover field width
  localparam int CNT_W      = 5;    // blocks_in_use register width
  localparam int CMP_W      = (SIZE_WIDTH > AMT_W) ? SIZE_WIDTH : AMT_W;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  have;
    logic [IDX_W-1:0]      best;
    logic [SIZE_WIDTH-1:0] size;
  } token_t;

  // control word broadcast to every cell
  typedef struct packed {
    logic                  commit;
    logic                  restore;
    logic [IDX_W-1:0]      commit_idx;
    logic [AMT_W-1:0]      amount;
    logic [SIZE_WIDTH-1:0] load_data;
  } cell_ctl_t;

endpackage

@@ design/bfa_if.sv @@
// Valid/ready channel interfaces for the best-fit allocator: request
// words in, result words out. Depends on bfa_pkg.
interface bfa_req_if
  import bfa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               op;
  logic [3:0]         block_index;
  logic [AMT_W-1:0]   amount;
  logic               last_request;

  modport source (output valid, op, block_index, amount, last_request, input ready);
  modport sink   (input valid, op, block_index, amount, last_request, output ready);
endinterface

interface bfa_rsp_if
  import bfa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               found;
  logic [NUM_W-1:0]   block_number;
  logic [LEFT_W-1:0]  leftover;
  logic               batch_done;

  modport source (output valid, found, block_number, leftover, batch_done, input ready);
  modport sink   (input valid, found, block_number, leftover, batch_done, output ready);
endinterface

@@ design/best_fit_allocator_top.sv @@
// Top level of the best-fit allocator: control sequencer, search count
// register and the row of bfa_cell entries. Depends on bfa_pkg, bfa_if.
//
//   channel   dir  handshake     payload
//   req       in   valid/ready   op, block_index, amount, last_request
//   rsp       out  valid/ready   found, block_number, leftover, batch_done
//   cfg       in   cfg_we        cfg_data (blocks_in_use)
//
// A load word is written into its entry at the accepting edge and gives
// no result. A request's token is launched at its accepting edge, walks
// one cell per cycle through the row, and the result register captures
// the result as the token leaves the last cell. The next word is taken
// at the edge the result leaves, so no new request is taken while a
// scan or result is pending. Reset clears both size tables and sets the
// search count to 16. A stalled result holds its register and blocks
// further words.
module best_fit_allocator_top
  import bfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_data,
  bfa_req_if.sink               req,
  bfa_rsp_if.source             rsp
);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  blocks_in_use;
  logic [AMT_W-1:0]  req_amount;
  logic              req_last;
  logic              accept;
  logic              start;
  logic              scan_done;
  token_t            tok [BLOCKS+1];
  cell_ctl_t         ctl;
  logic [BLOCKS-1:0] load_en;
  logic [BLOCKS-1:0] searched;
  logic              rsp_found;
  logic [NUM_W-1:0]  rsp_number;
  logic [LEFT_W-1:0] rsp_left;
  logic              rsp_batch;

  assign accept    = req.valid && req.ready;
  assign start     = accept && (req.op == OP_REQUEST);
  assign scan_done = (state == ST_SCAN) && tok[BLOCKS].valid;

  // search count register
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= COUNT_RESET;
    end else if (cfg_we) begin
      blocks_in_use <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (req.op == OP_REQUEST)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[BLOCKS].valid) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (rsp.ready) begin
          state_next = (accept && (req.op == OP_REQUEST)) ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: req.ready = 1'b0;
      ST_OUT: begin
        rsp.valid = 1'b1;
        req.ready = rsp.ready;
      end
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request operands held for the whole scan
  always_ff @(posedge clk) begin
    if (start) begin
      req_amount <= req.amount;
      req_last   <= req.last_request;
    end
  end

  // launch stage feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= start;
    end
    tok[0].have <= 1'b0;
    tok[0].best <= '0;
    tok[0].size <= '0;
  end

  // broadcast control and per-entry selects
  always_comb begin
    ctl.commit     = scan_done && tok[BLOCKS].have;
    ctl.restore    = scan_done && req_last;
    ctl.commit_idx = tok[BLOCKS].best;
    ctl.amount     = req_amount;
    ctl.load_data  = SIZE_WIDTH'(req.amount);
    for (int j = 0; j < BLOCKS; j++) begin
      load_en[j]  = accept && (req.op == OP_LOAD) && (int'(req.block_index) == j);
      searched[j] = j < int'(blocks_in_use);
    end
  end

  // row of entries
  for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
    bfa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (IDX_W'(g)),
      .load_en  (load_en[g]),
      .searched (searched[g]),
      .ctl      (ctl),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (scan_done) begin
      rsp_found  <= tok[BLOCKS].have;
      rsp_batch  <= req_last;
      if (tok[BLOCKS].have) begin
        rsp_number <= NUM_W'(tok[BLOCKS].best);
        rsp_left   <= LEFT_W'(tok[BLOCKS].size - SIZE_WIDTH'(req_amount));
      end else begin
        rsp_number <= '0;
        rsp_left   <= '0;
      end
    end
  end

  assign rsp.found        = rsp_found;
  assign rsp.block_number = rsp_number;
  assign rsp.leftover     = rsp_left;
  assign rsp.batch_done   = rsp_batch;

endmodule

@@ design/bfa_cell.sv @@
// One table entry of the allocator: original and free size, plus one
// stage of the best-fit scan chain. Depends on bfa_pkg.
module bfa_cell
  import bfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  logic             load_en,
  input  logic             searched,
  input  cell_ctl_t        ctl,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic [SIZE_WIDTH-1:0] orig_size;
  logic [SIZE_WIDTH-1:0] free_size;
  token_t                tok_next;
  logic                  take;

  // candidate test: fits the request and beats the best so far
  always_comb begin
    take = searched && (CMP_W'(free_size) >= CMP_W'(ctl.amount)) &&
           (!tok_in.have || (free_size < tok_in.size));
    tok_next = tok_in;
    if (take) begin
      tok_next.have = 1'b1;
      tok_next.best = cell_id;
      tok_next.size = free_size;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.have <= tok_next.have;
    tok_out.best <= tok_next.best;
    tok_out.size <= tok_next.size;
  end

  // entry storage: restore wins over the allocation in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      orig_size <= '0;
      free_size <= '0;
    end else if (load_en) begin
      orig_size <= ctl.load_data;
      free_size <= ctl.load_data;
    end else if (ctl.restore) begin
      free_size <= orig_size;
    end else if (ctl.commit && (ctl.commit_idx == cell_id)) begin
      free_size <= free_size - SIZE_WIDTH'(ctl.amount);
    end
  end

endmodule
